// ===== hw/rtl/cfsr_pkg.sv =====
// Shared constants, types and functions of the framed serial receiver.
package cfsr_pkg;

    // Saturation limit of the data byte count and position.
    localparam int COUNT_MAX = 255;

    // The stored byte count runs up to COUNT_MAX plus the five framing bytes.
    localparam int CNT_W     = $clog2(COUNT_MAX + 6);
    localparam int CLAMP_LIM = (COUNT_MAX < 255) ? COUNT_MAX : 255;

    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(COUNT_MAX + 5);
    localparam logic [CNT_W-1:0] CNT_HDR = CNT_W'(5);

    // Framing characters.
    localparam logic [7:0] START_CHAR = 8'h3A;
    localparam logic [7:0] CR_CHAR    = 8'h0D;
    localparam logic [7:0] LF_CHAR    = 8'h0A;

    // CRC-16/ARC polynomial 0x8005 in reflected form.
    localparam logic [15:0] POLY_REFL = 16'hA001;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_CRC_ERR = 2'd2,
        KIND_SHORT   = 2'd3
    } kind_t;

    // One result as it travels from the frame core to the output register.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_position;
        logic [7:0]  device_id;
        logic [7:0]  function_code;
        logic [7:0]  payload_count;
        logic [15:0] computed_check;
        logic [15:0] received_check;
    } result_t;

    // Byte-wide CRC-16/ARC update, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

    // Saturate a count at the limit and at eight bits.
    function automatic logic [7:0] clamp8(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v > CNT_W'(CLAMP_LIM)) ? CNT_W'(CLAMP_LIM) : v;
        return 8'(r);
    endfunction

endpackage

// ===== hw/rtl/cfsr_in_stage.sv =====
// Input register of the receiver: holds one accepted byte until the core takes it.
module cfsr_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);
    import cfsr_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       accept;

    // The register is free when empty or when its byte moves on this cycle.
    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Byte payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

// ===== hw/rtl/cfsr_frame_core.sv =====
// Frame parser: framing state, delay line, CRC accumulation and verdicts.
module cfsr_frame_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        byte_data,
    output logic              res_valid,
    output cfsr_pkg::result_t result
);
    import cfsr_pkg::*;

    logic             in_frame_reg, in_frame_next;
    logic             prev_cr_reg, prev_cr_next;
    logic [7:0]       win0_reg, win0_next;
    logic [7:0]       win1_reg, win1_next;
    logic [7:0]       win2_reg, win2_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       dev_reg, dev_next;
    logic [7:0]       fn_reg, fn_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      rx_check;

    // The check bytes sit in the two oldest window slots when LF arrives.
    assign rx_check = {win0_reg, win1_reg};

    // Next state and result for the byte being processed.
    always_comb
    begin
        in_frame_next = in_frame_reg;
        prev_cr_next  = prev_cr_reg;
        win0_next     = win0_reg;
        win1_next     = win1_reg;
        win2_next     = win2_reg;
        count_next    = count_reg;
        dev_next      = dev_reg;
        fn_next       = fn_reg;
        crc_next      = crc_reg;
        res_valid     = 1'b0;
        result        = '0;

        if (step)
        begin
            prev_cr_next = (byte_data == CR_CHAR);
            if (byte_data == START_CHAR)
            begin
                // Start character opens or restarts a frame.
                in_frame_next = 1'b1;
                win0_next     = '0;
                win1_next     = '0;
                win2_next     = '0;
                count_next    = '0;
                dev_next      = '0;
                fn_next       = '0;
                crc_next      = '0;
            end
            else if (in_frame_reg)
            begin
                if ((byte_data == LF_CHAR) && prev_cr_reg)
                begin
                    // End of frame: report the verdict.
                    in_frame_next        = 1'b0;
                    res_valid            = 1'b1;
                    result.device_id     = dev_reg;
                    result.function_code = fn_reg;
                    if (count_reg < CNT_HDR)
                    begin
                        result.kind = KIND_SHORT;
                    end
                    else
                    begin
                        result.kind           = (rx_check == crc_reg) ? KIND_GOOD
                                                                      : KIND_CRC_ERR;
                        result.payload_count  = clamp8(count_reg - CNT_HDR);
                        result.computed_check = crc_reg;
                        result.received_check = rx_check;
                    end
                end
                else
                begin
                    // Release the oldest window byte once it cannot be check or CR.
                    if (count_reg >= CNT_HDR)
                    begin
                        crc_next                = crc_byte(crc_reg, win0_reg);
                        res_valid               = 1'b1;
                        result.kind             = KIND_DATA;
                        result.payload_byte     = win0_reg;
                        result.payload_position = clamp8(count_reg - CNT_HDR);
                        result.device_id        = dev_reg;
                        result.function_code    = fn_reg;
                    end

                    // Capture the address and function bytes.
                    if (count_reg == '0)
                    begin
                        dev_next = byte_data;
                    end
                    else if (count_reg == CNT_W'(1))
                    begin
                        fn_next = byte_data;
                    end

                    win0_next = win1_reg;
                    win1_next = win2_reg;
                    win2_next = byte_data;
                    if (count_reg < CNT_TOP)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            prev_cr_reg  <= 1'b0;
            win0_reg     <= '0;
            win1_reg     <= '0;
            win2_reg     <= '0;
            count_reg    <= '0;
            dev_reg      <= '0;
            fn_reg       <= '0;
            crc_reg      <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            prev_cr_reg  <= prev_cr_next;
            win0_reg     <= win0_next;
            win1_reg     <= win1_next;
            win2_reg     <= win2_next;
            count_reg    <= count_next;
            dev_reg      <= dev_next;
            fn_reg       <= fn_next;
            crc_reg      <= crc_next;
        end
    end

endmodule

// ===== hw/rtl/cfsr_out_stage.sv =====
// Output register of the receiver: holds one result until the consumer takes it.
module cfsr_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  cfsr_pkg::result_t result,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_stall,
    output cfsr_pkg::result_t result_out
);
    import cfsr_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // The pipeline moves whenever the output register is empty or being taken.
    assign advance = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= res_valid;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

// ===== hw/rtl/crc_framed_serial_receiver.sv =====
// Receiver for ASCII-framed messages protected by CRC-16/ARC.
//
// Input channel: one received byte per request on rx_byte, qualified by in_valid
// and held off by in_stall. A ':' opens or restarts a frame, followed by device,
// function, data bytes, check high, check low, CR and LF.
// Output channel: one result per request, qualified by out_valid and held off by
// out_stall. Each data byte is released once three later bytes have arrived;
// an LF after CR yields a verdict (good, CRC mismatch or too short).
// Bytes that do not lead to a result (framing, header, check, stray bytes)
// produce no output request.
// An accepted byte goes from the input register through the combinational
// frame core; its result, if any, is captured in the result register.
// Throughput: one byte per cycle while out_stall is low; the byte-wide CRC update
// and the framing logic between the two registers set that figure.
// Reset clears the framing state and both valid flags; the block then waits for ':'.
// While out_stall holds a result, one more byte is still accepted into the input
// register; after that in_stall rises until the result is taken.
module crc_framed_serial_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  payload_position,
    output logic [7:0]  device_id,
    output logic [7:0]  function_code,
    output logic [7:0]  payload_count,
    output logic [15:0] computed_check,
    output logic [15:0] received_check
);
    import cfsr_pkg::*;

    logic       advance;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       res_valid;
    result_t    result;
    result_t    result_out;

    // Input register.
    cfsr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    // Frame parsing and CRC.
    cfsr_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (byte_valid && advance),
        .byte_data (byte_data),
        .res_valid (res_valid),
        .result    (result)
    );

    // Result register.
    cfsr_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_out (result_out)
    );

    assign result_kind      = result_out.kind;
    assign payload_byte     = result_out.payload_byte;
    assign payload_position = result_out.payload_position;
    assign device_id        = result_out.device_id;
    assign function_code    = result_out.function_code;
    assign payload_count    = result_out.payload_count;
    assign computed_check   = result_out.computed_check;
    assign received_check   = result_out.received_check;

endmodule

// ===== hw/rtl/cfsr_checker.sv =====
// Port-level checker for the framed serial receiver, bound to the top level.
module cfsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  result_kind,
    input logic [7:0]  payload_byte,
    input logic [7:0]  payload_count,
    input logic [15:0] computed_check,
    input logic [15:0] received_check
);
    import cfsr_pkg::*;

    // A stalled result stays in place.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_kind)
            && $stable(payload_byte) && $stable(computed_check))
        else $error("stalled result changed");

    // Data results carry no frame totals.
    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_DATA) |->
            (payload_count == 8'd0) && (computed_check == 16'd0)
            && (received_check == 16'd0))
        else $error("data result carries frame totals");

    // A too-short verdict carries no byte and no checks.
    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_SHORT) |->
            (payload_byte == 8'd0) && (payload_count == 8'd0)
            && (computed_check == 16'd0) && (received_check == 16'd0))
        else $error("short verdict carries data");

    // A good verdict has matching checks.
    a_good: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_GOOD) |-> computed_check == received_check)
        else $error("good verdict with differing checks");

    // A mismatch verdict has differing checks.
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_CRC_ERR) |-> computed_check != received_check)
        else $error("mismatch verdict with equal checks");

endmodule

bind crc_framed_serial_receiver cfsr_checker u_cfsr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .payload_byte   (payload_byte),
    .payload_count  (payload_count),
    .computed_check (computed_check),
    .received_check (received_check)
);
